@@ hdl/sbts_pkg.sv @@
// Shared types, constants and codes for the sorted beat table with snap search.
package sbts_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int TIME_W = 32;
	localparam int COUNT_OUT_W = 7;
	localparam logic [TIME_W-1:0] TOL_RESET = 32'd6554;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SNAP   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_APPLY,
		ST_DIST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] time_value;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]      snapped_time;
		logic                   snap_found;
		logic                   table_full;
		logic [COUNT_OUT_W-1:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic mark;
		logic lo_sel;
		logic hi_sel;
	} cell_stat_t;

	typedef struct packed {
		logic in_ready;
		logic mark_en;
		logic apply;
		logic finish;
	} ctrl_t;

endpackage

@@ hdl/sbts_cell.sv @@
// One table cell: holds a beat, flags it against the query and shifts right on insert.
module sbts_cell
	import sbts_pkg::*;
(
	input  logic              clk,
	input  logic              valid,
	input  logic              left_mark,
	input  logic              right_mark,
	input  logic [TIME_W-1:0] left_data,
	input  logic [TIME_W-1:0] query,
	input  logic              mark_en,
	input  logic              shift_en,
	output logic [TIME_W-1:0] data,
	output cell_stat_t        stat
);

	logic [TIME_W-1:0] data_q;
	logic              mark_q;

	always_ff @(posedge clk) begin
		if (mark_en) begin
			mark_q <= !valid || (data_q > query);
		end
		if (shift_en && mark_q) begin
			data_q <= left_mark ? left_data : query;
		end
	end

	assign data        = data_q;
	assign stat.mark   = mark_q;
	assign stat.lo_sel = !mark_q && right_mark;
	assign stat.hi_sel = mark_q && valid && !left_mark;

endmodule

@@ hdl/sbts_ctrl.sv @@
// Sequencer that steps one transaction through mark, apply, distance (snap only) and output.
module sbts_ctrl
	import sbts_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  is_snap,
	input  logic  out_free,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_MARK;
			ST_MARK:  state_d = ST_APPLY;
			ST_APPLY: state_d = is_snap ? ST_DIST : ST_DONE;
			ST_DIST:  state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_MARK:  ctrl.mark_en = 1'b1;
			ST_APPLY: ctrl.apply = 1'b1;
			ST_DONE:  ctrl.finish = out_free;
			default:  ctrl = '0;
		endcase
	end

endmodule

@@ hdl/sorted_beat_table_snap_top.sv @@
// Top level of the sorted beat table with insert, snap search and clear.
//
// Input transactions carry a command and a Q16.16 time on a valid/ready
// channel; every accepted transaction yields exactly one result on the
// output valid/ready channel, in order. The block works on one transaction
// at a time: once accepted, it steps the sequencer through mark, apply,
// distance (snap only) and done, and the done state loads the output
// register. The table is a row of TABLE_DEPTH cells; on insert the cell at
// the insertion point takes the new beat and each cell past it takes its
// left neighbor's beat, all in the apply step. A snap picks the two beats
// around the query from the row and compares their distances against the
// tolerance register. A finished result sits in the output register while
// the receiver stalls; the next transaction may still be accepted and
// processed, and it waits in its last step until the output register frees
// up. Reset empties the table and sets the tolerance register to 6554.
// The tolerance register is to be written by the user with cfg_wen only
// while the block is idle; the block itself does not enforce this.
module sorted_beat_table_snap_top
	import sbts_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_wen,
	input  logic [TIME_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	ctrl_t             ctrl;
	logic              in_fire;
	logic              out_free;
	logic              is_snap;
	logic              is_full;
	logic              shift_en;

	logic [1:0]        cmd_q;
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] tol_q;
	logic [CNT_W-1:0]  count_q;
	logic              full_q;
	logic [TIME_W-1:0] lo_q;
	logic [TIME_W-1:0] hi_q;
	logic              lo_have_q;
	logic              hi_have_q;
	logic [TIME_W-1:0] dlo_q;
	logic [TIME_W-1:0] dhi_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic [TIME_W-1:0] cell_data [TABLE_DEPTH];
	cell_stat_t        cell_stat [TABLE_DEPTH];
	logic [TIME_W-1:0] lo_pick;
	logic [TIME_W-1:0] hi_pick;
	logic              lo_have;
	logic              hi_have;
	logic              lo_ok;
	logic              hi_ok;
	out_item_t         result;

	assign in_ready = ctrl.in_ready;
	assign in_fire  = in_valid && ctrl.in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign is_snap  = (cmd_q == CMD_SNAP);
	assign is_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign shift_en = ctrl.apply && (cmd_q == CMD_INSERT) && !is_full;

	sbts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.is_snap  (is_snap),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic              left_mark;
		logic              right_mark;
		logic [TIME_W-1:0] left_data;

		if (g == 0) begin : g_first
			assign left_mark = 1'b0;
			assign left_data = t_q;
		end else begin : g_mid
			assign left_mark = cell_stat[g-1].mark;
			assign left_data = cell_data[g-1];
		end

		if (g == TABLE_DEPTH - 1) begin : g_last
			assign right_mark = 1'b1;
		end else begin : g_inner
			assign right_mark = cell_stat[g+1].mark;
		end

		sbts_cell u_cell (
			.clk        (clk),
			.valid      (count_q > CNT_W'(g)),
			.left_mark  (left_mark),
			.right_mark (right_mark),
			.left_data  (left_data),
			.query      (t_q),
			.mark_en    (ctrl.mark_en),
			.shift_en   (shift_en),
			.data       (cell_data[g]),
			.stat       (cell_stat[g])
		);
	end

	always_comb begin
		lo_pick = '0;
		hi_pick = '0;
		lo_have = 1'b0;
		hi_have = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			lo_pick = lo_pick | (cell_data[i] & {TIME_W{cell_stat[i].lo_sel}});
			hi_pick = hi_pick | (cell_data[i] & {TIME_W{cell_stat[i].hi_sel}});
			lo_have = lo_have | cell_stat[i].lo_sel;
			hi_have = hi_have | cell_stat[i].hi_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				tol_q <= cfg_wdata;
			end
			if (ctrl.apply) begin
				if (cmd_q == CMD_CLEAR) begin
					count_q <= '0;
				end else if (shift_en) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (ctrl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= in_data.command;
			t_q   <= in_data.time_value;
		end
		if (ctrl.apply) begin
			full_q    <= (cmd_q == CMD_INSERT) && is_full;
			lo_q      <= lo_pick;
			hi_q      <= hi_pick;
			lo_have_q <= lo_have;
			hi_have_q <= hi_have;
		end
		dlo_q <= t_q - lo_q;
		dhi_q <= hi_q - t_q;
		if (ctrl.finish) begin
			out_data_q <= result;
		end
	end

	assign lo_ok = lo_have_q && (dlo_q < tol_q);
	assign hi_ok = hi_have_q && (dhi_q < tol_q);

	always_comb begin
		result.snapped_time = t_q;
		result.snap_found   = 1'b0;
		result.table_full   = full_q;
		result.entry_count  = COUNT_OUT_W'(count_q);
		if (is_snap) begin
			if (lo_ok && (!hi_ok || dlo_q <= dhi_q)) begin
				result.snapped_time = lo_q;
				result.snap_found   = 1'b1;
			end else if (hi_ok) begin
				result.snapped_time = hi_q;
				result.snap_found   = 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ hdl/sbts_checker.sv @@
// Port-level checks for the sorted beat table, bound to the top level.
module sbts_checker
	import sbts_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Output transaction changed while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second transaction accepted while one is in flight.");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.snap_found && out_data.table_full))
		else $error("Snap and full flags set in the same result.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.table_full |->
			out_data.entry_count == COUNT_OUT_W'(TABLE_DEPTH))
		else $error("Dropped insert reported with a table that is not full.");

endmodule

bind sorted_beat_table_snap_top sbts_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sbts_checker (.*);

@@ tb/sorted_beat_table_snap_top_tb.sv @@
// Self-checking testbench for the sorted beat table with insert, snap search and clear.
`timescale 1ns / 1ps

module sorted_beat_table_snap_top_tb;
	import sbts_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 95;

	class beat_table_mirror;
		logic [TIME_W-1:0] beats [DEPTH];
		int unsigned count;
		logic [TIME_W-1:0] tolerance;
		out_item_t pending_results [$];
		int unsigned accepted, checked, errors;
		int unsigned inserts, drops, snaps, hits, clears;

		function new();
			count = 0;
			tolerance = TOL_RESET;
		endfunction

		function void set_tolerance(logic [TIME_W-1:0] value);
			tolerance = value;
		endfunction

		function void apply_command(in_item_t item);
			out_item_t want;
			int unsigned pos;
			logic have;
			logic [TIME_W-1:0] best, best_dist, gap;
			want.snapped_time = item.time_value;
			want.snap_found = 1'b0;
			want.table_full = 1'b0;
			have = 1'b0;
			best = '0;
			best_dist = '0;
			accepted++;
			case (item.command)
				CMD_INSERT: begin
					inserts++;
					if (count >= DEPTH) begin
						want.table_full = 1'b1;
						drops++;
					end else begin
						pos = count;
						for (int i = 0; i < count; i++) begin
							if (beats[i] > item.time_value) begin
								pos = i;
								break;
							end
						end
						for (int i = count; i > pos; i--)
							beats[i] = beats[i - 1];
						beats[pos] = item.time_value;
						count++;
					end
				end
				CMD_SNAP: begin
					snaps++;
					for (int i = 0; i < count; i++) begin
						gap = (beats[i] > item.time_value) ? beats[i] - item.time_value
							: item.time_value - beats[i];
						if (gap < tolerance && (!have || gap < best_dist)) begin
							have = 1'b1;
							best = beats[i];
							best_dist = gap;
						end
					end
					if (have) begin
						want.snapped_time = best;
						want.snap_found = 1'b1;
						hits++;
					end
				end
				CMD_CLEAR: begin
					clears++;
					count = 0;
				end
				default: ;
			endcase
			want.entry_count = 7'(count);
			pending_results.push_back(want);
		endfunction

		function void report(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		endfunction

		function void compare_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived with nothing expected", $time, got);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.snapped_time !== want.snapped_time)
				report("snapped_time", want.snapped_time, got.snapped_time);
			if (got.snap_found !== want.snap_found)
				report("snap_found", 32'(want.snap_found), 32'(got.snap_found));
			if (got.table_full !== want.table_full)
				report("table_full", 32'(want.table_full), 32'(got.table_full));
			if (got.entry_count !== want.entry_count)
				report("entry_count", 32'(want.entry_count), 32'(got.entry_count));
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_wen = 1'b0;
	logic [TIME_W-1:0] cfg_wdata = '0;

	beat_table_mirror board = new();
	int unsigned burst_left = 0;
	int unsigned counted_items = 0;
	int unsigned tolerance_writes = 0;

	sorted_beat_table_snap_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.compare_result(out_data);
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : receiver
		int unsigned seg, mode;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && board.accepted >= 150) begin
				held = 1'b1;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 2);
			seg = $urandom_range(10, 60);
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic send_item(in_item_t item);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		board.apply_command(item);
		burst_left--;
	endtask

	task automatic issue_command(logic [1:0] cmd, logic [TIME_W-1:0] value);
		in_item_t item;
		item.command = cmd;
		item.time_value = value;
		send_item(item);
		if (cmd != CMD_UNUSED)
			counted_items++;
	endtask

	task automatic drain_table_ops();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_tolerance(logic [TIME_W-1:0] value);
		drain_table_ops();
		cfg_wdata <= value;
		cfg_wen <= 1'b1;
		@(negedge clk);
		cfg_wen <= 1'b0;
		board.set_tolerance(value);
		tolerance_writes++;
	endtask

	task automatic cluster_sequence();
		logic [TIME_W-1:0] base, spread, pick, other, query;
		logic [TIME_W-1:0] placed [$];
		int unsigned k, m;
		if ($urandom_range(0, 2) == 0)
			issue_command(CMD_CLEAR, $urandom);
		case ($urandom_range(0, 3))
			0: base = $urandom;
			1: base = $urandom_range(0, 32'h0001_0000);
			2: base = 32'hFFFF_FFFF - $urandom_range(0, 32'h0001_0000);
			default: base = {16'($urandom_range(0, 600)), 16'h0000};
		endcase
		case ($urandom_range(0, 3))
			0: spread = 0;
			1: spread = 64;
			2: spread = board.tolerance;
			default: spread = 32'h0004_0000;
		endcase
		k = $urandom_range(1, 16);
		repeat (k) begin
			pick = base + $urandom_range(0, spread);
			placed.push_back(pick);
			issue_command(CMD_INSERT, pick);
		end
		m = $urandom_range(2, 12);
		repeat (m) begin
			pick = placed[$urandom_range(0, placed.size() - 1)];
			other = placed[$urandom_range(0, placed.size() - 1)];
			case ($urandom_range(0, 5))
				0: query = pick;
				1: query = pick + board.tolerance - 1;
				2: query = pick - board.tolerance;
				3: query = pick + (board.tolerance >> 1);
				4: query = (pick >> 1) + (other >> 1) + (pick & other & 32'd1);
				default: query = $urandom;
			endcase
			issue_command(CMD_SNAP, query);
		end
	endtask

	task automatic fill_table_sequence();
		logic [TIME_W-1:0] base;
		base = $urandom;
		issue_command(CMD_CLEAR, $urandom);
		repeat (DEPTH) issue_command(CMD_INSERT, base + $urandom_range(0, 32'h0010_0000));
		repeat ($urandom_range(1, 3)) issue_command(CMD_INSERT, $urandom);
		repeat ($urandom_range(2, 6))
			issue_command(CMD_SNAP, base + $urandom_range(0, 32'h0010_0000));
		issue_command(CMD_UNUSED, $urandom);
	endtask

	task automatic noise_sequence();
		repeat ($urandom_range(3, 10)) issue_command(2'($urandom_range(0, 3)), $urandom);
	endtask

	initial begin : stimulus
		logic [TIME_W-1:0] tol_list [6];
		int unsigned target, pick;
		tol_list[0] = 32'h0000_0000;
		tol_list[1] = 32'hFFFF_FFFF;
		tol_list[2] = 32'd1;
		tol_list[3] = $urandom_range(1, 32'h0002_0000);
		tol_list[4] = 32'h0001_0000;
		tol_list[5] = TOL_RESET;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		issue_command(CMD_SNAP, 32'h0001_0000);
		issue_command(CMD_UNUSED, 32'hFFFF_FFFF);
		issue_command(CMD_INSERT, 32'h0002_0000);
		issue_command(CMD_INSERT, 32'h0001_0000);
		issue_command(CMD_INSERT, 32'h0002_0000);
		issue_command(CMD_INSERT, 32'h0000_0000);
		issue_command(CMD_INSERT, 32'hFFFF_FFFF);
		issue_command(CMD_SNAP, 32'h0001_0000);
		issue_command(CMD_SNAP, 32'h0001_0000 + TOL_RESET - 1);
		issue_command(CMD_SNAP, 32'h0001_0000 + TOL_RESET);
		issue_command(CMD_INSERT, 32'h0003_0000);
		issue_command(CMD_INSERT, 32'h0003_2000);
		issue_command(CMD_SNAP, 32'h0003_1000);
		issue_command(CMD_SNAP, 32'hFFFF_FFFF);
		issue_command(CMD_SNAP, 32'hFFFF_F000);
		issue_command(CMD_SNAP, 32'h0000_0005);
		issue_command(CMD_UNUSED, 32'h0003_0000);
		issue_command(CMD_CLEAR, 32'h5555_AAAA);
		issue_command(CMD_SNAP, 32'h0002_0000);
		issue_command(CMD_INSERT, 32'h8000_0000);
		issue_command(CMD_SNAP, 32'h8000_0001);

		for (int phase = 0; phase < 6; phase++) begin
			write_tolerance(tol_list[phase]);
			target = counted_items + ITEMS_PER_PHASE;
			if (phase == 0)
				fill_table_sequence();
			while (counted_items < target) begin
				pick = $urandom_range(0, 19);
				if (pick < 12)
					cluster_sequence();
				else if (pick < 15)
					fill_table_sequence();
				else
					noise_sequence();
			end
		end

		drain_table_ops();
		$write("Checked %0d transactions: %0d inserts (%0d dropped on a full table), ",
			board.checked, board.inserts, board.drops);
		$display("%0d snaps (%0d found), %0d clears.", board.snaps, board.hits, board.clears);
		$write("Covered %0d tolerance settings from zero to all ones, ", tolerance_writes);
		$display("bursty input and a %0d-cycle output hold-off.", HOLD_CYCLES);
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sbts_pkg.sv
hdl/sbts_cell.sv
hdl/sbts_ctrl.sv
hdl/sorted_beat_table_snap_top.sv
hdl/sbts_checker.sv
tb/sorted_beat_table_snap_top_tb.sv
